// ===== hdl/csr_pkg.sv =====
package csr_pkg;

    // Beat widths on the streaming ports.
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 24;

    // Fixed field widths.
    localparam int IDX_FIELD_W = 6;
    localparam int CNT_FIELD_W = 7;
    localparam int STAT_W      = 3;
    localparam int CFG_W       = 7;

    localparam logic [CNT_FIELD_W-1:0] CNT_SAT = 7'd127;
    localparam logic [CFG_W-1:0] SLOT_COUNT_RESET = 7'd64;

    // Request kinds carried on tuser.
    localparam logic KIND_RESERVE = 1'b0;
    localparam logic KIND_RESOLVE = 1'b1;

    // Per-slot state codes held in the slot table.
    localparam logic [1:0] SLOT_AVAIL = 2'd0;
    localparam logic [1:0] SLOT_RESV  = 2'd1;
    localparam logic [1:0] SLOT_TAKEN = 2'd2;

    // Result status codes.
    localparam logic [STAT_W-1:0] RES_RESERVED = 3'd0;
    localparam logic [STAT_W-1:0] RES_RETRY    = 3'd1;
    localparam logic [STAT_W-1:0] RES_FULL     = 3'd2;
    localparam logic [STAT_W-1:0] RES_RESOLVED = 3'd3;
    localparam logic [STAT_W-1:0] RES_ERROR    = 3'd4;

    // Classified request flags passed from the front to the back.
    typedef struct packed {
        logic kind;
        logic bad;
        logic commit;
    } req_ctrl_t;

    // One result beat; status sits in the lowest bits.
    typedef struct packed {
        logic [CNT_FIELD_W-1:0] taken;
        logic [CNT_FIELD_W-1:0] reserved;
        logic [IDX_FIELD_W-1:0] found;
        logic [STAT_W-1:0]      status;
    } res_t;

endpackage

// ===== hdl/circular_slot_reserver.sv =====
// Circular slot reserver. Keeps MAX_SLOTS slots, each available, reserved or
// taken, of which the first slot_count (clamped to 1..MAX_SLOTS) are in use.
// A reserve beat (tuser 0) searches circularly from start_index modulo the
// active count and reserves the first available slot, or answers retry (some
// slot reserved) or full; a resolve beat (tuser 1) commits a reserved slot to
// taken or releases it, and answers error for a slot out of range or not
// reserved. Every request gives exactly one result beat carrying the status,
// the slot index and the reserved and taken counts after the step. After
// reset the slot table is cleared in a pass over all MAX_SLOTS entries, during
// which s_tready stays low. A reserve is slower than a resolve, because its
// start index is reduced by a six-step remainder and the search reads the slot
// table through its single read port at one slot per cycle. A two-entry queue
// separates the input classifier from the slot engine, and a result register
// lets the next request be taken while a result waits on m_tready.
module circular_slot_reserver import csr_pkg::*; #(
    parameter int MAX_SLOTS = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_W-1:0]      cfg_data,  // slot_count
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // start_index[5:0], slot_index[11:6], commit[12]
    input  logic                  s_tuser,   // kind
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata    // status[2:0], found_index[8:3],
                                             // reserved_now[15:9], taken_now[22:16]
);

    localparam int IW   = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CW   = $clog2(MAX_SLOTS + 1);
    localparam int SW   = (CW > CFG_W) ? CW : CFG_W;
    localparam int QW   = $bits(req_ctrl_t) + IW;
    localparam int QDEP = 2;

    logic [CFG_W-1:0] slot_count_reg, slot_count_next;
    logic [SW-1:0] sc_ext;
    logic [CW-1:0] n_active;

    logic front_valid, front_ready;
    req_ctrl_t front_ctrl;
    logic [IW-1:0] front_idx;
    logic q_valid, q_ready;
    logic [QW-1:0] q_data;
    req_ctrl_t q_ctrl;
    logic [IW-1:0] q_idx;
    logic init_done;
    res_t out_res;

    // Slot count register, always ready.
    assign cfg_ready = 1'b1;
    assign slot_count_next = (cfg_valid && cfg_ready) ? cfg_data : slot_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_count_reg <= SLOT_COUNT_RESET;
        end else begin
            slot_count_reg <= slot_count_next;
        end
    end

    // Active count: zero acts as one, anything above the table acts as its size.
    assign sc_ext = SW'(slot_count_reg);
    always_comb begin
        if (sc_ext == '0) begin
            n_active = CW'(1);
        end else if (sc_ext > SW'(MAX_SLOTS)) begin
            n_active = CW'(MAX_SLOTS);
        end else begin
            n_active = CW'(sc_ext);
        end
    end

    csr_front #(
        .MAX_SLOTS(MAX_SLOTS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .init_done(init_done),
        .n        (n_active),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .req_valid(front_valid),
        .req_ready(front_ready),
        .req_ctrl (front_ctrl),
        .req_idx  (front_idx)
    );

    csr_fifo #(
        .WIDTH(QW),
        .DEPTH(QDEP)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (front_valid),
        .in_ready (front_ready),
        .in_data  ({front_ctrl, front_idx}),
        .out_valid(q_valid),
        .out_ready(q_ready),
        .out_data (q_data)
    );

    assign q_ctrl = q_data[QW-1:IW];
    assign q_idx  = q_data[IW-1:0];

    csr_back #(
        .MAX_SLOTS(MAX_SLOTS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .n        (n_active),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_ctrl   (q_ctrl),
        .q_idx    (q_idx),
        .init_done(init_done),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_res  (out_res)
    );

    assign m_tdata = OUT_DATA_W'(out_res);

endmodule

// ===== hdl/csr_ram.sv =====
module csr_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/csr_fifo.sv =====
module csr_fifo #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 2,
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int NW = $clog2(DEPTH + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0] cnt_reg, cnt_next;
    logic push, pop;

    assign in_ready  = (cnt_reg != NW'(DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid & in_ready;
    assign pop       = out_valid & out_ready;

    // Pointer and fill-level update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + NW'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - NW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

// ===== hdl/csr_front.sv =====
module csr_front import csr_pkg::*; #(
    parameter int MAX_SLOTS = 64,
    localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1,
    localparam int CW = $clog2(MAX_SLOTS + 1)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 init_done,
    input  logic [CW-1:0]        n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_DATA_W-1:0] s_tdata,  // start_index[5:0], slot_index[11:6], commit[12]
    input  logic                 s_tuser,  // kind
    output logic                 req_valid,
    input  logic                 req_ready,
    output req_ctrl_t            req_ctrl,
    output logic [IW-1:0]        req_idx
);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_MOD  = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;

    localparam int CMPW = (CW > IDX_FIELD_W) ? CW : IDX_FIELD_W;

    logic [1:0] fstate_reg, fstate_next;
    logic [2:0] bit_reg, bit_next;
    logic [CW-1:0] rem_reg, rem_next;
    logic [IDX_FIELD_W-1:0] start_reg, start_next;
    req_ctrl_t ctrl_reg, ctrl_next;
    logic [IW-1:0] idx_reg, idx_next;

    logic [IDX_FIELD_W-1:0] in_start;
    logic [IDX_FIELD_W-1:0] in_slot;
    logic in_commit;
    logic accept;
    logic [CW:0] trial;
    logic [CW:0] diff;
    logic [CW-1:0] rem_step;

    assign in_start  = s_tdata[5:0];
    assign in_slot   = s_tdata[11:6];
    assign in_commit = s_tdata[12];

    assign s_tready  = (fstate_reg == F_IDLE) && init_done;
    assign accept    = s_tvalid && s_tready;
    assign req_valid = (fstate_reg == F_PUSH);
    assign req_ctrl  = ctrl_reg;
    assign req_idx   = idx_reg;

    // One restoring remainder step: brings in the next start bit from the top.
    assign trial    = {rem_reg, start_reg[bit_reg]};
    assign diff     = trial - {1'b0, n};
    assign rem_step = (trial >= {1'b0, n}) ? diff[CW-1:0] : trial[CW-1:0];

    // Classify the beat: a resolve is range checked at once, a reserve
    // reduces its start index modulo the active slot count first.
    always_comb begin
        fstate_next = fstate_reg;
        bit_next    = bit_reg;
        rem_next    = rem_reg;
        start_next  = start_reg;
        ctrl_next   = ctrl_reg;
        idx_next    = idx_reg;
        case (fstate_reg)
            F_IDLE: begin
                if (accept) begin
                    start_next       = in_start;
                    ctrl_next.kind   = s_tuser;
                    ctrl_next.commit = in_commit;
                    ctrl_next.bad    = 1'b0;
                    if (s_tuser == KIND_RESOLVE) begin
                        ctrl_next.bad = (CMPW'(in_slot) >= CMPW'(n));
                        idx_next      = IW'(in_slot);
                        fstate_next   = F_PUSH;
                    end else begin
                        rem_next    = '0;
                        bit_next    = 3'(IDX_FIELD_W - 1);
                        fstate_next = F_MOD;
                    end
                end
            end
            F_MOD: begin
                rem_next = rem_step;
                bit_next = bit_reg - 3'd1;
                if (bit_reg == 3'd0) begin
                    idx_next    = IW'(rem_step);
                    fstate_next = F_PUSH;
                end
            end
            F_PUSH: begin
                if (req_ready) begin
                    fstate_next = F_IDLE;
                end
            end
            default: begin
                fstate_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fstate_reg <= F_IDLE;
        end else begin
            fstate_reg <= fstate_next;
        end
    end

    // Request payload and remainder datapath.
    always_ff @(posedge aclk) begin
        bit_reg   <= bit_next;
        rem_reg   <= rem_next;
        start_reg <= start_next;
        ctrl_reg  <= ctrl_next;
        idx_reg   <= idx_next;
    end

endmodule

// ===== hdl/csr_back.sv =====
module csr_back import csr_pkg::*; #(
    parameter int MAX_SLOTS = 64,
    localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1,
    localparam int CW = $clog2(MAX_SLOTS + 1)
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic [CW-1:0] n,
    input  logic          q_valid,
    output logic          q_ready,
    input  req_ctrl_t     q_ctrl,
    input  logic [IW-1:0] q_idx,
    output logic          init_done,
    output logic          out_valid,
    input  logic          out_ready,
    output res_t          out_res
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    localparam int SATW = (CW > CNT_FIELD_W) ? CW : CNT_FIELD_W;
    localparam int SUMW = CW + 1;

    logic [2:0] state_reg, state_next;
    logic [IW-1:0] clr_reg, clr_next;
    logic [IW-1:0] pos_reg, pos_next;
    logic [CW-1:0] seen_reg, seen_next;
    logic [STAT_W-1:0] status_reg, status_next;
    logic [IW-1:0] found_reg, found_next;
    logic commit_reg, commit_next;
    logic [CW-1:0] res_cnt_reg, res_cnt_next;
    logic [CW-1:0] taken_cnt_reg, taken_cnt_next;
    logic out_valid_reg, out_valid_next;
    res_t out_res_reg, out_res_next;

    logic ram_we;
    logic [IW-1:0] ram_waddr;
    logic [1:0] ram_wdata;
    logic [IW-1:0] ram_raddr;
    logic [1:0] ram_rdata;

    logic [IW-1:0] wrap_pos;
    logic out_free;
    logic [STAT_W-1:0] final_status;
    logic [CW-1:0] res_after;
    logic [CW-1:0] taken_after;
    logic [SATW-1:0] res_ext;
    logic [SATW-1:0] taken_ext;

    csr_ram #(
        .WIDTH(2),
        .DEPTH(MAX_SLOTS)
    ) u_slot_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign init_done = (state_reg != S_CLEAR);
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;
    assign out_free  = !out_valid_reg || out_ready;

    // Next slot of the circular search, wrapping at the active count.
    assign wrap_pos = ((CW'(pos_reg) + CW'(1)) == n) ? '0 : pos_reg + IW'(1);

    // A failed search is held as retry and becomes full when nothing is reserved.
    assign final_status = ((status_reg == RES_RETRY) && (res_cnt_reg == '0)) ?
                          RES_FULL : status_reg;

    // Counts after the pending step.
    always_comb begin
        res_after   = res_cnt_reg;
        taken_after = taken_cnt_reg;
        if (status_reg == RES_RESERVED) begin
            res_after = res_cnt_reg + CW'(1);
        end else if (status_reg == RES_RESOLVED) begin
            res_after = res_cnt_reg - CW'(1);
            if (commit_reg) begin
                taken_after = taken_cnt_reg + CW'(1);
            end
        end
    end

    assign res_ext   = SATW'(res_after);
    assign taken_ext = SATW'(taken_after);

    // Slot engine: clearing pass, circular scan, resolve check, result write.
    always_comb begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        pos_next       = pos_reg;
        seen_next      = seen_reg;
        status_next    = status_reg;
        found_next     = found_reg;
        commit_next    = commit_reg;
        res_cnt_next   = res_cnt_reg;
        taken_cnt_next = taken_cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_res_next   = out_res_reg;
        ram_we         = 1'b0;
        ram_waddr      = pos_reg;
        ram_wdata      = SLOT_AVAIL;
        ram_raddr      = pos_reg;
        q_ready        = 1'b0;
        case (state_reg)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                if (clr_reg == IW'(MAX_SLOTS - 1)) begin
                    state_next = S_IDLE;
                end else begin
                    clr_next = clr_reg + IW'(1);
                end
            end
            S_IDLE: begin
                q_ready   = 1'b1;
                ram_raddr = q_idx;
                if (q_valid) begin
                    pos_next    = q_idx;
                    seen_next   = '0;
                    commit_next = q_ctrl.commit;
                    if (q_ctrl.kind == KIND_RESERVE) begin
                        state_next = S_SCAN;
                    end else if (q_ctrl.bad) begin
                        status_next = RES_ERROR;
                        found_next  = '0;
                        state_next  = S_DONE;
                    end else begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_SCAN: begin
                // Read data belongs to pos_reg; the next slot is already being read.
                ram_raddr = wrap_pos;
                if (ram_rdata == SLOT_AVAIL) begin
                    status_next = RES_RESERVED;
                    found_next  = pos_reg;
                    state_next  = S_DONE;
                end else if ((seen_reg + CW'(1)) == n) begin
                    status_next = RES_RETRY;
                    found_next  = '0;
                    state_next  = S_DONE;
                end else begin
                    pos_next  = wrap_pos;
                    seen_next = seen_reg + CW'(1);
                end
            end
            S_CHECK: begin
                if (ram_rdata == SLOT_RESV) begin
                    status_next = RES_RESOLVED;
                    found_next  = pos_reg;
                end else begin
                    status_next = RES_ERROR;
                    found_next  = '0;
                end
                state_next = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    ram_we    = (status_reg == RES_RESERVED) || (status_reg == RES_RESOLVED);
                    ram_waddr = found_reg;
                    if (status_reg == RES_RESERVED) begin
                        ram_wdata = SLOT_RESV;
                    end else if (commit_reg) begin
                        ram_wdata = SLOT_TAKEN;
                    end else begin
                        ram_wdata = SLOT_AVAIL;
                    end
                    res_cnt_next          = res_after;
                    taken_cnt_next        = taken_after;
                    out_valid_next        = 1'b1;
                    out_res_next.status   = final_status;
                    out_res_next.found    = IDX_FIELD_W'(found_reg);
                    out_res_next.reserved = (res_ext > SATW'(CNT_SAT)) ?
                                            CNT_SAT : res_ext[CNT_FIELD_W-1:0];
                    out_res_next.taken    = (taken_ext > SATW'(CNT_SAT)) ?
                                            CNT_SAT : taken_ext[CNT_FIELD_W-1:0];
                    state_next            = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            res_cnt_reg   <= '0;
            taken_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            res_cnt_reg   <= res_cnt_next;
            taken_cnt_reg <= taken_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working payload of the current request.
    always_ff @(posedge aclk) begin
        pos_reg     <= pos_next;
        seen_reg    <= seen_next;
        status_reg  <= status_next;
        found_reg   <= found_next;
        commit_reg  <= commit_next;
        out_res_reg <= out_res_next;
    end

`ifndef SYNTHESIS
    a_counts_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (SUMW'(res_cnt_reg) + SUMW'(taken_cnt_reg)) <= SUMW'(MAX_SLOTS))
        else $error("reserved plus taken count exceeds the slot table");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result beat raised outside the completion state");

    a_scan_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN) |-> ((seen_reg < n) && (CW'(pos_reg) < n)))
        else $error("circular scan ran past the active slot count");

    a_found_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == S_DONE) && ((status_reg == RES_RESERVED) ||
         (status_reg == RES_RESOLVED))) |-> (CW'(found_reg) < n))
        else $error("slot write outside the active slot count");
`endif

endmodule
